[design/assert_macros.svh]
// assertion macros shared by the vertex transform rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds while reset is asserted
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/hvt_pkg.sv]
// package: types and constants of the homogeneous vertex transform
package hvt_pkg;

    localparam int DIV_BITS = 48;
    localparam int DIV_STAGES = DIV_BITS;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    localparam logic [63:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
    localparam logic [63:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
    localparam logic [63:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;
    localparam logic [63:0] ROW_W_RESET = 64'h0100_0000_0000_0000;

    typedef enum logic [1:0] {
        REG_ROW_X = 2'd0,
        REG_ROW_Y = 2'd1,
        REG_ROW_Z = 2'd2,
        REG_ROW_W = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
    } t_vertex_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               w_was_zero;
        logic               saturated;
    } t_vertex_out;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic               sat;
    } t_mm_word;

    typedef struct packed {
        logic [31:0]        rem;
        logic [DIV_BITS-1:0] nq;
        logic               neg;
        logic signed [31:0] orig;
    } t_div_lane;

    typedef struct packed {
        logic               valid;
        logic [31:0]        divisor;
        logic               bypass;
        logic               w_zero;
        logic               sat;
        logic signed [31:0] w;
    } t_div_ctx;

endpackage

[design/hvt_cfg.sv]
// apb register block holding the four matrix rows
module hvt_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output logic [3:0][63:0]  o_rows
);

    logic [3:0][63:0] r_rows;
    logic             wr;
    hvt_pkg::t_reg_idx idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = hvt_pkg::t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows[hvt_pkg::REG_ROW_X] <= hvt_pkg::ROW_X_RESET;
            r_rows[hvt_pkg::REG_ROW_Y] <= hvt_pkg::ROW_Y_RESET;
            r_rows[hvt_pkg::REG_ROW_Z] <= hvt_pkg::ROW_Z_RESET;
            r_rows[hvt_pkg::REG_ROW_W] <= hvt_pkg::ROW_W_RESET;
        end else if (wr) begin
            r_rows[idx] <= pwdata;
        end
    end

    assign prdata = r_rows[idx];
    assign o_rows = r_rows;

endmodule

[design/hvt_matmul.sv]
// two-stage 4x4 matrix multiply with floor shift and saturation
module hvt_matmul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  hvt_pkg::t_vertex_in  i_data,
    input  logic [3:0][63:0]     i_rows,
    output hvt_pkg::t_mm_word    o_word
);

    logic signed [3:0][3:0][47:0] r_prod;
    logic                         r_prod_valid;
    hvt_pkg::t_mm_word            r_word;

    logic signed [31:0] v [4];
    logic signed [47:0] n_prod [4][4];
    logic signed [31:0] res [4];
    logic        [3:0]  row_sat;

    always_comb begin
        v[0] = i_data.in_x;
        v[1] = i_data.in_y;
        v[2] = i_data.in_z;
        v[3] = i_data.in_w;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_prod[i][j] = $signed(i_rows[i][16*j +: 16]) * v[j];
            end
        end
    end

    // sum, floor shift by 8, clip to 32 bits
    always_comb begin
        logic signed [49:0] sum;
        logic signed [49:0] sh;
        for (int i = 0; i < 4; i++) begin
            sum = 50'($signed(r_prod[i][0])) + 50'($signed(r_prod[i][1]))
                + 50'($signed(r_prod[i][2])) + 50'($signed(r_prod[i][3]));
            sh = sum >>> 8;
            if (sh > 50'sh0_0000_7FFF_FFFF) begin
                res[i] = 32'sh7FFF_FFFF;
                row_sat[i] = 1'b1;
            end else if (sh < -50'sh0_0000_8000_0000) begin
                res[i] = 32'sh8000_0000;
                row_sat[i] = 1'b1;
            end else begin
                res[i] = sh[31:0];
                row_sat[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_word.valid <= 1'b0;
        end else if (i_en) begin
            r_prod_valid <= i_valid;
            r_word.valid <= r_prod_valid;
        end
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[i][j] <= n_prod[i][j];
                end
            end
            r_word.x   <= res[0];
            r_word.y   <= res[1];
            r_word.z   <= res[2];
            r_word.w   <= res[3];
            r_word.sat <= |row_sat;
        end
    end

    assign o_word = r_word;

endmodule

[design/hvt_div_step.sv]
// one restoring division step for the three dividend lanes
module hvt_div_step (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  hvt_pkg::t_div_ctx         i_ctx,
    input  hvt_pkg::t_div_lane [2:0]  i_lanes,
    output hvt_pkg::t_div_ctx         o_ctx,
    output hvt_pkg::t_div_lane [2:0]  o_lanes
);

    hvt_pkg::t_div_ctx        r_ctx;
    hvt_pkg::t_div_lane [2:0] r_lanes;
    hvt_pkg::t_div_lane [2:0] n_lanes;

    always_comb begin
        logic [32:0] t;
        logic [32:0] d;
        logic        ge;
        d = {1'b0, i_ctx.divisor};
        for (int k = 0; k < 3; k++) begin
            t  = {i_lanes[k].rem, i_lanes[k].nq[hvt_pkg::DIV_BITS-1]};
            ge = (t >= d);
            n_lanes[k]      = i_lanes[k];
            n_lanes[k].rem  = ge ? 32'(t - d) : t[31:0];
            n_lanes[k].nq   = {i_lanes[k].nq[hvt_pkg::DIV_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.valid <= 1'b0;
        end else if (i_en) begin
            r_ctx.valid <= i_ctx.valid;
        end
        if (i_en) begin
            r_ctx.divisor <= i_ctx.divisor;
            r_ctx.bypass  <= i_ctx.bypass;
            r_ctx.w_zero  <= i_ctx.w_zero;
            r_ctx.sat     <= i_ctx.sat;
            r_ctx.w       <= i_ctx.w;
            r_lanes       <= n_lanes;
        end
    end

    assign o_ctx   = r_ctx;
    assign o_lanes = r_lanes;

endmodule

[design/hvt_divider.sv]
// pipelined perspective divide of x, y and z by w, one quotient bit a stage
module hvt_divider (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  hvt_pkg::t_mm_word    i_word,
    output logic                 o_valid,
    output hvt_pkg::t_vertex_out o_data
);

    hvt_pkg::t_div_ctx        ctx_s   [hvt_pkg::DIV_STAGES+1];
    hvt_pkg::t_div_lane [2:0] lanes_s [hvt_pkg::DIV_STAGES+1];

    logic                 r_valid;
    hvt_pkg::t_vertex_out r_data;
    hvt_pkg::t_vertex_out n_data;

    // operand set-up: magnitudes, signs and the skip cases
    always_comb begin
        logic signed [31:0] comp [3];
        logic        [31:0] mag;
        comp[0] = i_word.x;
        comp[1] = i_word.y;
        comp[2] = i_word.z;
        ctx_s[0].valid   = i_word.valid;
        ctx_s[0].w_zero  = (i_word.w == 32'sd0);
        ctx_s[0].bypass  = (i_word.w == 32'sd0) || (i_word.w == hvt_pkg::Q_ONE);
        ctx_s[0].sat     = i_word.sat;
        ctx_s[0].w       = i_word.w;
        ctx_s[0].divisor = ctx_s[0].bypass ? 32'd1
                         : (i_word.w[31] ? 32'(-i_word.w) : 32'(i_word.w));
        for (int k = 0; k < 3; k++) begin
            mag = comp[k][31] ? 32'(-comp[k]) : 32'(comp[k]);
            lanes_s[0][k].rem  = '0;
            lanes_s[0][k].nq   = {mag, 16'h0000};
            lanes_s[0][k].neg  = comp[k][31] ^ i_word.w[31];
            lanes_s[0][k].orig = comp[k];
        end
    end

    for (genvar s = 0; s < hvt_pkg::DIV_STAGES; s++) begin : g_step
        hvt_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_ctx   (ctx_s[s]),
            .i_lanes (lanes_s[s]),
            .o_ctx   (ctx_s[s+1]),
            .o_lanes (lanes_s[s+1])
        );
    end

    // sign restore and clip of the quotients
    always_comb begin
        hvt_pkg::t_div_ctx  c;
        logic [hvt_pkg::DIV_BITS-1:0] q;
        logic signed [31:0] res [3];
        logic        [2:0]  qsat;
        c = ctx_s[hvt_pkg::DIV_STAGES];
        for (int k = 0; k < 3; k++) begin
            q = lanes_s[hvt_pkg::DIV_STAGES][k].nq;
            qsat[k] = 1'b0;
            if (c.bypass) begin
                res[k] = lanes_s[hvt_pkg::DIV_STAGES][k].orig;
            end else if (lanes_s[hvt_pkg::DIV_STAGES][k].neg) begin
                if (q > 48'h0000_8000_0000) begin
                    res[k]  = 32'sh8000_0000;
                    qsat[k] = 1'b1;
                end else begin
                    res[k] = 32'(-q[31:0]);
                end
            end else begin
                if (q > 48'h0000_7FFF_FFFF) begin
                    res[k]  = 32'sh7FFF_FFFF;
                    qsat[k] = 1'b1;
                end else begin
                    res[k] = q[31:0];
                end
            end
        end
        n_data.out_x      = res[0];
        n_data.out_y      = res[1];
        n_data.out_z      = res[2];
        n_data.out_w      = c.w;
        n_data.w_was_zero = c.w_zero;
        n_data.saturated  = c.sat || (|qsat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= ctx_s[hvt_pkg::DIV_STAGES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[design/homogeneous_vertex_transform_unit.sv]
// Homogeneous 4x4 vertex transform with perspective divide. One vertex word is taken per
// clock while o_stall is low and one result leaves per clock while i_stall is low. It has
// two stages of multiply and row sum, 48 stages of a pipelined restoring divider giving
// one quotient bit each, one stage of sign and clip, and the output register. A one-word
// skid buffer at the output keeps o_stall a register, so a held result does not hold up
// the input until the skid is full. The user must write matrix rows over the apb port at
// byte addresses 0, 8, 16 and 24 only while the block is idle, which it does not enforce.
module homogeneous_vertex_transform_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  hvt_pkg::t_vertex_in  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output hvt_pkg::t_vertex_out o_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    `include "assert_macros.svh"

    logic [3:0][63:0]     rows;
    logic                 en;
    hvt_pkg::t_mm_word    mm_word;
    logic                 div_valid;
    hvt_pkg::t_vertex_out div_data;

    logic                 r_out_valid;
    hvt_pkg::t_vertex_out r_out;
    logic                 r_skid_valid;
    hvt_pkg::t_vertex_out r_skid;
    logic                 take;

    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign take    = r_out_valid && !i_stall;

    hvt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rows  (rows)
    );

    hvt_matmul u_matmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_rows  (rows),
        .o_word  (mm_word)
    );

    hvt_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_word  (mm_word),
        .o_valid (div_valid),
        .o_data  (div_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (div_valid) begin
            if (!r_out_valid || take) begin
                r_out       <= div_data;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= div_data;
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `ASSERT_ALWAYS(a_skid_behind_out, i_clk, r_skid_valid |-> r_out_valid, "skid full with empty output")
    `ASSERT_CLK(a_skid_drains, i_clk, i_rst_n, (r_skid_valid && !i_stall) |=> !r_skid_valid, "skid did not drain")
    `ASSERT_CLK(a_wzero_flag, i_clk, i_rst_n, (o_valid && o_data.w_was_zero) |-> (o_data.out_w == 32'sd0), "zero flag with nonzero w")

endmodule

[tb/vertex_checker.sv]
// checker: watches both vertex channels, predicts each transformed word and compares
module vertex_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  hvt_pkg::t_vertex_in  i_data,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  hvt_pkg::t_vertex_out o_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [63:0]          pwdata,
    input  logic                 pready,
    output int                   fail_count,
    output int                   pending_count,
    output int                   results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] matrix_rows [4];
    hvt_pkg::t_vertex_out expected_vertices [$];

    function automatic logic signed [31:0] clip_word(input logic signed [127:0] v,
                                                     inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] row_sum(input logic [63:0] row,
                                                   input hvt_pkg::t_vertex_in v,
                                                   inout logic sat);
        logic signed [127:0] acc;
        logic signed [127:0] comp [4];
        comp[0] = v.in_x;
        comp[1] = v.in_y;
        comp[2] = v.in_z;
        comp[3] = v.in_w;
        acc = 0;
        for (int j = 0; j < 4; j++)
            acc += $signed(row[16*j +: 16]) * comp[j];
        // arithmetic shift floors toward minus infinity
        return clip_word(acc >>> 8, sat);
    endfunction

    function automatic logic signed [31:0] divide_by_w(input logic signed [31:0] num,
                                                       input logic signed [31:0] w,
                                                       inout logic sat);
        logic signed [127:0] n;
        logic signed [127:0] d;
        n = num;
        n = n * 128'sd65536;
        d = w;
        return clip_word(n / d, sat);
    endfunction

    function automatic hvt_pkg::t_vertex_out transform_vertex(input hvt_pkg::t_vertex_in v);
        hvt_pkg::t_vertex_out r;
        logic sat;
        sat = 1'b0;
        r.out_x = row_sum(matrix_rows[hvt_pkg::REG_ROW_X], v, sat);
        r.out_y = row_sum(matrix_rows[hvt_pkg::REG_ROW_Y], v, sat);
        r.out_z = row_sum(matrix_rows[hvt_pkg::REG_ROW_Z], v, sat);
        r.out_w = row_sum(matrix_rows[hvt_pkg::REG_ROW_W], v, sat);
        r.w_was_zero = (r.out_w == 0);
        if (r.out_w != 0 && r.out_w != hvt_pkg::Q_ONE) begin
            r.out_x = divide_by_w(r.out_x, r.out_w, sat);
            r.out_y = divide_by_w(r.out_y, r.out_w, sat);
            r.out_z = divide_by_w(r.out_z, r.out_w, sat);
        end
        r.saturated = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        hvt_pkg::t_vertex_out want;
        if (!i_rst_n) begin
            matrix_rows[hvt_pkg::REG_ROW_X] <= hvt_pkg::ROW_X_RESET;
            matrix_rows[hvt_pkg::REG_ROW_Y] <= hvt_pkg::ROW_Y_RESET;
            matrix_rows[hvt_pkg::REG_ROW_Z] <= hvt_pkg::ROW_Z_RESET;
            matrix_rows[hvt_pkg::REG_ROW_W] <= hvt_pkg::ROW_W_RESET;
            fail_count <= 0;
            results_seen <= 0;
            pending_count <= 0;
            expected_vertices.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                matrix_rows[paddr[4:3]] <= pwdata;
            if (i_valid && !o_stall)
                expected_vertices.push_back(transform_vertex(i_data));
            if (o_valid && !i_stall) begin
                results_seen <= results_seen + 1;
                if (expected_vertices.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result word %h", o_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_vertices.pop_front();
                    if (want !== o_data) begin
                        if (fail_count < 10)
                            $display("mismatch: expected x %h y %h z %h w %h wz %b sat %b, got x %h y %h z %h w %h wz %b sat %b",
                                     want.out_x, want.out_y, want.out_z, want.out_w,
                                     want.w_was_zero, want.saturated,
                                     o_data.out_x, o_data.out_y, o_data.out_z,
                                     o_data.out_w, o_data.w_was_zero, o_data.saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_vertices.size();
        end
    end
endmodule

[tb/testbench.sv]
// testbench top: drives vertices, matrix writes and output stalls around the transform unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    hvt_pkg::t_vertex_in  i_data = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    hvt_pkg::t_vertex_out o_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [4:0]           paddr = '0;
    logic [63:0]          pwdata = '0;
    logic [63:0]          prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending_count;
    int                   results_seen;
    int                   vertices_sent = 0;

    homogeneous_vertex_transform_unit dut (.*);

    vertex_checker checker_inst (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0001_0000;
            3: return 32'hffff_0000;
            4: return 32'h0;
            5: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] random_row(input int style);
        logic [63:0] r;
        for (int j = 0; j < 4; j++)
            case (style)
                0: r[16*j +: 16] = 16'($urandom);
                1: r[16*j +: 16] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                default: r[16*j +: 16] = $signed(16'($urandom_range(0, 1024))) - 16'sd512;
            endcase
        return r;
    endfunction

    task automatic write_row(input hvt_pkg::t_reg_idx idx, input logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_vertex(input hvt_pkg::t_vertex_in v);
        int gap;
        gap = gap_length();
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= v;
        do @(posedge i_clk); while (o_stall);
        vertices_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic random_vertices(input int count);
        hvt_pkg::t_vertex_in v;
        for (int k = 0; k < count; k++) begin
            v.in_x = $urandom_range(0, 2) == 0 ? edge_word() : $signed($urandom) >>> $urandom_range(0, 12);
            v.in_y = $urandom_range(0, 2) == 0 ? edge_word() : $signed($urandom) >>> $urandom_range(0, 12);
            v.in_z = $urandom_range(0, 2) == 0 ? edge_word() : $signed($urandom) >>> $urandom_range(0, 12);
            v.in_w = $urandom_range(0, 2) == 0 ? edge_word() : $signed($urandom) >>> $urandom_range(0, 14);
            send_vertex(v);
        end
    endtask

    // output stall: bursts of random holds with quiet stretches
    always @(negedge i_clk) begin
        if (!i_rst_n || ($urandom_range(0, 63) < 2))
            i_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 12)
            i_stall <= ($urandom_range(0, 9) == 0) || (i_stall == 1'b0);
        else if (i_stall && $urandom_range(0, 2) == 0)
            i_stall <= 1'b0;
    end

    initial begin
        hvt_pkg::t_vertex_in v;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // identity matrix: w one, w zero, extremes and a normal divide
        v = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000, 32'sh0001_0000};
        send_vertex(v);
        v = '{32'sh0003_0000, -32'sh0002_0000, 32'sh7fff_ffff, 32'sh0};
        send_vertex(v);
        v = '{32'sh0005_0000, 32'sh0006_0000, -32'sh0007_0000, 32'sh0002_0000};
        send_vertex(v);
        v = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0001};
        send_vertex(v);
        v = '{32'sh8000_0000, 32'sh0, 32'sh1, 32'sh8000_0000};
        send_vertex(v);
        v = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000};
        send_vertex(v);
        v = '{-32'sh1, 32'sh7fff_ffff, -32'sh1, 32'sh7fff_ffff};
        send_vertex(v);
        drain();

        // extreme coefficients force row sum clipping and negative floor shift
        write_row(hvt_pkg::REG_ROW_X, 64'h7fff_7fff_7fff_7fff);
        write_row(hvt_pkg::REG_ROW_Y, 64'h8000_8000_8000_8000);
        write_row(hvt_pkg::REG_ROW_Z, 64'hffff_0001_ffff_0001);
        write_row(hvt_pkg::REG_ROW_W, 64'h0100_0000_0000_0000);
        v = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh0001_0000};
        send_vertex(v);
        v = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh0002_0000};
        send_vertex(v);
        v = '{32'sh1, 32'sh3, -32'sh5, 32'sh0};
        send_vertex(v);
        v = '{32'shffff_ffff, 32'sh0, 32'sh0, 32'sh0000_0001};
        send_vertex(v);
        random_vertices(200);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            for (int r = 0; r < 4; r++)
                write_row(hvt_pkg::t_reg_idx'(r), random_row(phase % 3));
            random_vertices(200);
            drain();
        end

        // back to identity with a small w row so quotients overflow
        write_row(hvt_pkg::REG_ROW_X, hvt_pkg::ROW_X_RESET);
        write_row(hvt_pkg::REG_ROW_Y, hvt_pkg::ROW_Y_RESET);
        write_row(hvt_pkg::REG_ROW_Z, hvt_pkg::ROW_Z_RESET);
        write_row(hvt_pkg::REG_ROW_W, 64'h0001_0000_0000_0000);
        random_vertices(40);
        drain();

        $display("sent %0d vertices over nine matrix settings, %0d results checked",
                 vertices_sent, results_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout after %0d vertices", vertices_sent);
        $display("Test completed with failures");
        $finish;
    end
endmodule
